>>> hdl/srlc_pkg.sv
// Shared types and constants of the S-record loader and checker.
`timescale 1ns / 1ps
`default_nettype none
package srlc_pkg;
	typedef enum logic [1:0] {
		OP_FEED = 2'd0,
		OP_READ = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_DATA_OK = 4'd0,
		ST_HEADER_OK = 4'd1,
		ST_END = 4'd2,
		ST_NO_S = 4'd3,
		ST_BAD_TYPE = 4'd4,
		ST_BAD_HEX = 4'd5,
		ST_LENGTH = 4'd6,
		ST_CHECKSUM = 4'd7,
		ST_IGNORED = 4'd8
	} status_t;

	localparam logic [1:0] MODE_LOADING = 2'd0;
	localparam logic [1:0] MODE_STOPPED = 2'd1;
	localparam logic [1:0] MODE_DONE = 2'd2;

	localparam logic [3:0] NO_TYPE = 4'd15;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [6:0] GLYPH_DOT = 7'h2E;
	localparam logic [9:0] POS_MAX = 10'd1023;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
		return r;
	endfunction
endpackage
`default_nettype wire

>>> hdl/srlc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module srlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> hdl/srecord_loader_checker.sv
// Top level of the S-record loader and checker.
// Input channel s_axis: one beat carries an opcode (feed a character, read a byte,
// restart). Output channel m_axis: one beat per record end (status) or per read.
// A feed character other than CR/LF is taken in its accept cycle and the block
// stays idle; a read passes through S_READ (memory read) and S_RDATA (registered
// data, output), and then its beat is offered.
// A valid S1 record end walks its staged data bytes into the byte memory, each
// by a staging read (S_CRD) then a memory write (S_CWR), and its status beat is
// offered after the last write. The walk goes through the single-port staging
// and byte memories.
// s_axis_tready is low while an item is in work or while an undelivered result
// occupies the output register; a stalled receiver holds the result and the
// block takes no new beat. Reset clears parse state and sets loading mode;
// memory contents are undefined until written and are kept across restart.
`timescale 1ns / 1ps
`default_nettype none
module srecord_loader_checker #(
	parameter int ADDRESS_BITS = 16,
	parameter int MAX_RECORD_BYTES = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[1:0], record_char[9:2], access_address[25:10], zero[31:26]
	input wire logic [31:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// record_status[3:0], record_kind[7:4], record_address[23:8],
	// bytes_loaded[31:24], read_byte[39:32], display_glyph[46:40], zero[47]
	output logic [47:0] m_axis_tdata,
	// result_kind
	output logic m_axis_tuser
);
	import srlc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_RDATA = 5'b00100,
		S_CRD = 5'b01000,
		S_CWR = 5'b10000
	} state_t;

	state_t state_q;
	logic [9:0] pos_q;
	logic [3:0] hi_q, err_q, type_q;
	logic [7:0] sum_q, cnt_q, idx_q, n_q;
	logic [1:0] mode_q;
	logic [15:0] la_q;
	logic [ADDRESS_BITS-1:0] waddr_q;
	logic [ADDRESS_BITS-1:0] raddr_q;

	logic [1:0] op;
	logic [7:0] ch;
	logic [15:0] acc;
	assign op = s_axis_tdata[1:0];
	assign ch = s_axis_tdata[9:2];
	assign acc = s_axis_tdata[25:10];

	logic take;
	assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
	assign take = s_axis_tvalid && s_axis_tready;

	logic sg_we, bm_we;
	logic [7:0] sg_addr, sg_wd, sg_rd, bm_rd;
	logic [ADDRESS_BITS-1:0] bm_addr;

	srlc_ram #(.WIDTH(8), .DEPTH(256)) u_stage (
		.clk(clk), .we(sg_we), .addr(sg_addr), .wdata(sg_wd), .rdata(sg_rd));
	srlc_ram #(.WIDTH(8), .DEPTH(1 << ADDRESS_BITS)) u_mem (
		.clk(clk), .we(bm_we), .addr(bm_addr), .wdata(sg_rd), .rdata(bm_rd));

	logic [4:0] hv;
	logic [8:0] pidx;
	logic [7:0] bval;
	logic [9:0] digits;
	logic feed, eol;
	assign hv = hex_value(ch);
	assign digits = pos_q - 10'd2;
	assign pidx = digits[9:1];
	assign bval = {hi_q, hv[3:0]};
	assign feed = take && (op == OP_FEED);
	assign eol = (ch == CH_CR) || (ch == CH_LF);

	logic char_pair;
	assign char_pair = feed && !eol && pos_q >= 10'd2 && !hv[4] && digits[0];
	assign sg_we = char_pair && (pidx < 9'(MAX_RECORD_BYTES));
	assign sg_wd = bval;
	assign sg_addr = (state_q == S_IDLE) ? pidx[7:0] : idx_q + 8'd3;
	assign bm_we = (state_q == S_CWR);
	assign bm_addr = (state_q == S_CWR) ? waddr_q :
		(state_q == S_READ) ? raddr_q : ADDRESS_BITS'(acc);

	logic [3:0] fstat;
	always_comb begin
		fstat = err_q;
		if (fstat == 4'd0 && pos_q < 10'd2) fstat = ST_BAD_TYPE;
		if (fstat == 4'd0) begin
			if (digits[0] || cnt_q < 8'd3 || {1'b0, pidx} != {2'b0, cnt_q} + 10'd1)
				fstat = ST_LENGTH;
			else if (sum_q != 8'hFF)
				fstat = ST_CHECKSUM;
		end
	end

	task automatic clr;
		pos_q <= '0; hi_q <= '0; sum_q <= '0; cnt_q <= '0;
		err_q <= '0; type_q <= NO_TYPE; la_q <= '0;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_axis_tvalid <= 1'b0;
			mode_q <= MODE_LOADING;
			pos_q <= '0; hi_q <= '0; sum_q <= '0; cnt_q <= '0;
			err_q <= '0; type_q <= NO_TYPE; la_q <= '0;
			idx_q <= '0; n_q <= '0; waddr_q <= '0; raddr_q <= '0;
			m_axis_tdata <= '0; m_axis_tuser <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take && op == OP_RESTART) begin
						clr();
						mode_q <= MODE_LOADING;
					end else if (take && op == OP_READ) begin
						raddr_q <= ADDRESS_BITS'(acc);
						state_q <= S_READ;
					end else if (feed && eol) begin
						if (pos_q != 10'd0) begin
							m_axis_tuser <= 1'b0;
							clr();
							if (mode_q != MODE_LOADING) begin
								m_axis_tdata <= {16'd0, 8'd0, 16'd0, 4'd0, ST_IGNORED};
								m_axis_tvalid <= 1'b1;
							end else if (type_q == 4'd9) begin
								m_axis_tdata <= {16'd0, 8'd0, la_q, 4'd9, ST_END};
								mode_q <= MODE_DONE;
								m_axis_tvalid <= 1'b1;
							end else if (fstat != 4'd0) begin
								m_axis_tdata <= {16'd0, 8'd0, 16'd0, 4'd0, fstat};
								mode_q <= MODE_STOPPED;
								m_axis_tvalid <= 1'b1;
							end else if (type_q == 4'd0) begin
								m_axis_tdata <= {16'd0, 8'd0, la_q, 4'd0, ST_HEADER_OK};
								m_axis_tvalid <= 1'b1;
							end else begin
								m_axis_tdata <= {16'd0, cnt_q - 8'd3, la_q, type_q,
									ST_DATA_OK};
								n_q <= cnt_q - 8'd3;
								idx_q <= '0;
								waddr_q <= ADDRESS_BITS'(la_q);
								if (cnt_q == 8'd3) m_axis_tvalid <= 1'b1;
								else state_q <= S_CRD;
							end
						end
					end else if (feed) begin
						if (pos_q == 10'd0) begin
							if (ch != CH_S && err_q == 4'd0) err_q <= ST_NO_S;
						end else if (pos_q == 10'd1) begin
							if (ch == CH_0) type_q <= 4'd0;
							else if (ch == CH_1) type_q <= 4'd1;
							else if (ch == CH_9) type_q <= 4'd9;
							else if (err_q == 4'd0) err_q <= ST_BAD_TYPE;
						end else begin
							if (pos_q >= 10'd4 && pos_q <= 10'd7)
								la_q <= {la_q[11:0], hv[4] ? 4'd0 : hv[3:0]};
							if (hv[4]) begin
								if (err_q == 4'd0) err_q <= ST_BAD_HEX;
							end else if (!digits[0]) begin
								hi_q <= hv[3:0];
							end else begin
								if (pidx >= 9'(MAX_RECORD_BYTES)) begin
									if (err_q == 4'd0) err_q <= ST_LENGTH;
								end else if (pidx == 9'd0) begin
									cnt_q <= bval;
								end
								sum_q <= sum_q + bval;
							end
						end
						if (pos_q != POS_MAX) pos_q <= pos_q + 10'd1;
					end
				end
				S_READ: state_q <= S_RDATA;
				S_RDATA: begin
					m_axis_tuser <= 1'b1;
					m_axis_tdata <= {1'b0, (bm_rd >= 8'h20 && bm_rd <= 8'h7F) ?
						bm_rd[6:0] : GLYPH_DOT, bm_rd, 32'd0};
					m_axis_tvalid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					waddr_q <= waddr_q + 1'b1;
					idx_q <= idx_q + 8'd1;
					if (idx_q + 8'd1 == n_q) begin
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the S-record loader: record streams, reads and restarts checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import srlc_pkg::*;

	typedef struct {
		logic        is_read;
		status_t     status;
		logic [3:0]  kind;
		logic [15:0] addr;
		logic [7:0]  loaded;
		logic [7:0]  rbyte;
		logic [6:0]  glyph;
	} srec_outcome_t;

	class srec_scoreboard;
		logic [7:0]  mem [65536];
		logic [7:0]  stage [256];
		int          pos;
		logic [3:0]  hi;
		logic [7:0]  sum;
		logic [7:0]  dcnt;
		status_t     err;
		logic [1:0]  mode;
		logic [3:0]  rtype;
		logic [15:0] laddr;
		logic [15:0] written_q [$];
		srec_outcome_t outcomes_q [$];
		int          failures;
		int          status_seen [9];
		int          reads_seen;

		function new();
			failures = 0;
			reads_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			mode = MODE_LOADING;
			clear_parse();
		endfunction

		function void clear_parse();
			pos = 0;
			hi = 0;
			sum = 0;
			dcnt = 0;
			err = ST_DATA_OK;
			rtype = NO_TYPE;
			laddr = 0;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "a" && c <= "f") return c - "a" + 10;
			if (c >= "A" && c <= "F") return c - "A" + 10;
			return -1;
		endfunction

		function void flag(status_t code);
			if (err == ST_DATA_OK) err = code;
		endfunction

		function void take_char(logic [7:0] c);
			int v;
			int idx;
			logic [7:0] b;
			v = hex_nibble(c);
			if (pos == 0) begin
				if (c != CH_S) flag(ST_NO_S);
			end else if (pos == 1) begin
				if (c == CH_0) rtype = 0;
				else if (c == CH_1) rtype = 1;
				else if (c == CH_9) rtype = 9;
				else flag(ST_BAD_TYPE);
			end else begin
				if (pos >= 4 && pos <= 7) laddr = {laddr[11:0], (v < 0) ? 4'h0 : 4'(v)};
				if (v < 0) flag(ST_BAD_HEX);
				else if (((pos - 2) & 1) == 0) hi = 4'(v);
				else begin
					idx = (pos - 2) >> 1;
					b = {hi, 4'(v)};
					if (idx >= 256) flag(ST_LENGTH);
					else begin
						stage[idx] = b;
						if (idx == 0) dcnt = b;
					end
					sum = sum + b;
				end
			end
			if (pos < POS_MAX) pos++;
		endfunction

		function srec_outcome_t close_record();
			srec_outcome_t o;
			int nbytes;
			o = '{1'b0, ST_DATA_OK, 4'd0, 16'd0, 8'd0, 8'd0, 7'd0};
			if (mode != MODE_LOADING) o.status = ST_IGNORED;
			else if (rtype == 9) begin
				o.status = ST_END;
				o.kind = 9;
				o.addr = laddr;
				mode = MODE_DONE;
			end else begin
				o.status = err;
				if (o.status == ST_DATA_OK && pos < 2) o.status = ST_BAD_TYPE;
				if (o.status == ST_DATA_OK) begin
					nbytes = (pos - 2) >> 1;
					if (((pos - 2) & 1) != 0 || dcnt < 3 || nbytes != dcnt + 1)
						o.status = ST_LENGTH;
					else if (sum != 8'hFF)
						o.status = ST_CHECKSUM;
				end
				if (o.status == ST_DATA_OK) begin
					o.kind = rtype;
					o.addr = laddr;
					if (rtype == 0) o.status = ST_HEADER_OK;
					else begin
						for (int i = 0; i < dcnt - 3; i++) begin
							mem[16'(laddr + i)] = stage[3 + i];
							written_q.push_back(16'(laddr + i));
						end
						o.loaded = dcnt - 3;
					end
				end else mode = MODE_STOPPED;
			end
			clear_parse();
			return o;
		endfunction

		function void note_beat(opcode_t op, logic [7:0] c, logic [15:0] a);
			srec_outcome_t o;
			case (op)
				OP_FEED: begin
					if (c == CH_CR || c == CH_LF) begin
						if (pos != 0) outcomes_q.push_back(close_record());
					end else take_char(c);
				end
				OP_READ: begin
					o = '{1'b1, ST_DATA_OK, 4'd0, 16'd0, 8'd0, mem[a], 7'd0};
					o.glyph = (o.rbyte >= 8'h20 && o.rbyte <= 8'h7F) ? o.rbyte[6:0] : GLYPH_DOT;
					outcomes_q.push_back(o);
				end
				OP_RESTART: begin
					clear_parse();
					mode = MODE_LOADING;
				end
				default: ;
			endcase
		endfunction

		function void check_beat(logic [47:0] d, logic user);
			srec_outcome_t e;
			if (outcomes_q.size() == 0) begin
				$display("%0t: unexpected result beat tdata=%h tuser=%b", $time, d, user);
				failures++;
				return;
			end
			e = outcomes_q.pop_front();
			if (e.is_read) reads_seen++;
			else status_seen[e.status]++;
			if (user !== e.is_read) begin
				$display("%0t: result_kind expected %b actual %b", $time, e.is_read, user);
				failures++;
			end
			if (d[3:0] !== e.status) begin
				$display("%0t: record_status expected %0d actual %0d", $time, e.status, d[3:0]);
				failures++;
			end
			if (d[7:4] !== e.kind) begin
				$display("%0t: record_kind expected %0d actual %0d", $time, e.kind, d[7:4]);
				failures++;
			end
			if (d[23:8] !== e.addr) begin
				$display("%0t: record_address expected %h actual %h", $time, e.addr, d[23:8]);
				failures++;
			end
			if (d[31:24] !== e.loaded) begin
				$display("%0t: bytes_loaded expected %0d actual %0d", $time, e.loaded, d[31:24]);
				failures++;
			end
			if (d[39:32] !== e.rbyte) begin
				$display("%0t: read_byte expected %h actual %h", $time, e.rbyte, d[39:32]);
				failures++;
			end
			if (d[46:40] !== e.glyph) begin
				$display("%0t: display_glyph expected %h actual %h", $time, e.glyph, d[46:40]);
				failures++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 600;

	typedef enum int {
		FLAW_NONE, FLAW_CSUM, FLAW_HEX, FLAW_DROP, FLAW_NO_S, FLAW_TYPE, FLAW_COUNT, FLAW_LONG
	} flaw_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	logic        in_ready_q;
	logic        out_valid_q;
	logic [47:0] out_data_q;
	logic        out_user_q;
	logic        no_idle;
	logic        long_hold;
	int          cycles;
	int          chars_fed;
	srec_scoreboard sb;

	srecord_loader_checker uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		in_ready_q = s_axis_tready;
		out_valid_q = m_axis_tvalid;
		out_data_q = m_axis_tdata;
		out_user_q = m_axis_tuser;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("srecord_loader_checker test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid_q && m_axis_tready) sb.check_beat(out_data_q, out_user_q);
	end

	// receiver: random stall per beat, one long hold on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				stall = 400;
				long_hold = 1'b0;
			end else stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!out_valid_q);
		end
	end

	task automatic send(opcode_t op, logic [7:0] c, logic [15:0] a);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, a, c, op};
		do @(posedge clk); while (!in_ready_q);
		sb.note_beat(op, c, a);
		if (op == OP_FEED) chars_fed++;
	endtask

	task automatic feed(logic [7:0] c);
		send(OP_FEED, c, 16'($urandom));
	endtask

	task automatic end_line();
		case ($urandom_range(0, 2))
			0: feed(CH_CR);
			1: feed(CH_LF);
			default: begin
				feed(CH_CR);
				feed(CH_LF);
			end
		endcase
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		logic [7:0] c;
		c = (n < 10) ? 8'("0" + n) : 8'("A" + n - 10);
		if (n >= 10 && $urandom_range(0, 1)) c = c + 8'h20;
		return c;
	endfunction

	task automatic put_record(logic [7:0] tchar, logic [15:0] a, int n, flaw_t flaw);
		logic [7:0] body [$];
		logic [7:0] text [$];
		logic [7:0] csum;
		int k;
		body.push_back(8'(n + 3));
		if (flaw == FLAW_COUNT) body[0] = body[0] + 8'($urandom_range(1, 255));
		body.push_back(a[15:8]);
		body.push_back(a[7:0]);
		for (int i = 0; i < n; i++) body.push_back(8'($urandom));
		csum = 0;
		foreach (body[i]) csum = csum + body[i];
		csum = ~csum;
		if (flaw == FLAW_CSUM) csum = csum ^ (8'd1 << $urandom_range(0, 7));
		body.push_back(csum);
		text.push_back((flaw == FLAW_NO_S) ? 8'($urandom_range(0, 255) & 8'hDF | 8'h40) : CH_S);
		if (flaw == FLAW_NO_S && text[0] == CH_S) text[0] = "s";
		text.push_back((flaw == FLAW_TYPE) ? 8'("2" + $urandom_range(0, 6)) : tchar);
		foreach (body[i]) begin
			text.push_back(hex_char(body[i][7:4]));
			text.push_back(hex_char(body[i][3:0]));
		end
		if (flaw == FLAW_LONG) repeat (520) text.push_back(hex_char(4'($urandom)));
		k = $urandom_range(2, text.size() - 1);
		if (flaw == FLAW_HEX) text[k] = "G" + 8'($urandom_range(0, 20));
		if (flaw == FLAW_DROP) text.delete(k);
		foreach (text[i]) begin
			if (text[i] == CH_CR || text[i] == CH_LF) text[i] = "x";
			feed(text[i]);
		end
		end_line();
	endtask

	task automatic read_back();
		logic [15:0] a;
		if (sb.written_q.size() == 0) return;
		a = sb.written_q[$urandom_range(0, sb.written_q.size() - 1)];
		send(OP_READ, 8'($urandom), a);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.outcomes_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		no_idle = 1'b0;
		long_hold = 1'b0;
		cycles = 0;
		chars_fed = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		feed(CH_LF);
		put_record(CH_0, 16'h0000, 4, FLAW_NONE);
		put_record(CH_1, 16'h0000, 6, FLAW_NONE);
		put_record(CH_1, 16'hFFFE, 4, FLAW_NONE);
		put_record(CH_1, 16'h1234, 0, FLAW_NONE);
		put_record(CH_1, 16'h8000, 252, FLAW_NONE);
		repeat (6) read_back();
		send(OP_NONE, 8'hFF, 16'hFFFF);
		put_record(CH_1, 16'h4000, 3, FLAW_CSUM);
		put_record(CH_1, 16'h4000, 3, FLAW_NONE);
		send(OP_RESTART, 8'h00, 16'h0000);
		feed(CH_S);
		feed(CH_CR);
		send(OP_RESTART, 8'h00, 16'h0000);
		for (int f = FLAW_HEX; f <= FLAW_LONG; f++) begin
			put_record(CH_1, 16'($urandom), 2, flaw_t'(f));
			send(OP_RESTART, 8'h00, 16'h0000);
		end
		feed(CH_S);
		feed(CH_9);
		feed("z");
		feed(CH_CR);
		put_record(CH_1, 16'h0100, 2, FLAW_NONE);
		send(OP_RESTART, 8'h00, 16'h0000);

		// random
		while (chars_fed < 2000) begin
			if (sb.mode != MODE_LOADING && $urandom_range(0, 9) != 0)
				send(OP_RESTART, 8'($urandom), 16'($urandom));
			pick = $urandom_range(0, 99);
			if (pick < 2) no_idle = ~no_idle;
			if (pick == 50) begin
				drain();
				long_hold = 1'b1;
			end
			if (pick < 60)
				put_record(CH_1, 16'($urandom), ($urandom_range(0, 40) == 0) ?
					$urandom_range(0, 252) : $urandom_range(0, 12), FLAW_NONE);
			else if (pick < 66) put_record(CH_0, 16'($urandom), $urandom_range(0, 8), FLAW_NONE);
			else if (pick < 78) repeat ($urandom_range(1, 6)) read_back();
			else if (pick < 90)
				put_record(CH_1, 16'($urandom), $urandom_range(0, 8),
					flaw_t'($urandom_range(FLAW_CSUM, FLAW_COUNT)));
			else if (pick < 94) put_record(CH_9, 16'($urandom), 0, FLAW_NONE);
			else if (pick < 97) send(OP_NONE, 8'($urandom), 16'($urandom));
			else repeat ($urandom_range(1, 8)) feed(8'($urandom));
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("fed %0d characters; reads %0d; data ok %0d, header %0d, end %0d, ignored %0d",
			chars_fed, sb.reads_seen, sb.status_seen[ST_DATA_OK], sb.status_seen[ST_HEADER_OK],
			sb.status_seen[ST_END], sb.status_seen[ST_IGNORED]);
		$display("faults seen: no S %0d, type %0d, hex %0d, length %0d, checksum %0d",
			sb.status_seen[ST_NO_S], sb.status_seen[ST_BAD_TYPE], sb.status_seen[ST_BAD_HEX],
			sb.status_seen[ST_LENGTH], sb.status_seen[ST_CHECKSUM]);
		if (sb.failures == 0 && sb.outcomes_q.size() == 0)
			$display("srecord_loader_checker test passed");
		else
			$display("srecord_loader_checker test failed");
		$finish;
	end
endmodule
`default_nettype wire
